// ===== src/bfac_pkg.sv =====
// Package with shared types, constants and hash helpers for the bloom filter core.
`default_nettype none
package bfac_pkg;

    localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;
    localparam logic [63:0] KEY_LEN = 64'd20;

    localparam logic [0:0] CFG_SIZE_LOG2  = 1'b0;
    localparam logic [0:0] CFG_HASH_COUNT = 1'b1;
    localparam int CFG_IDX_W = 5;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef struct packed {
        logic [31:0] key_bytes_16_19;
        logic [63:0] key_bytes_8_15;
        logic [63:0] key_bytes_0_7;
        logic        req_type;
    } bfac_in_t;

    typedef struct packed {
        logic was_check;
        logic maybe_present;
    } bfac_out_t;

    // Hash datapath micro-op selects.
    typedef enum logic [3:0] {
        OP_INIT, OP_L0A, OP_L0B, OP_L0C, OP_MIX0, OP_L1A, OP_L1B, OP_L1C,
        OP_MIX1, OP_W2, OP_MIX2, OP_F1, OP_F2, OP_F3, OP_HOLD
    } bfac_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_HASH, ST_RD, ST_RDWAIT, ST_TEST,
        ST_WR, ST_NEXT, ST_OUT
    } bfac_state_t;

    typedef struct packed {
        logic     load_key;
        logic     seed_clr;
        logic     seed_inc;
        bfac_op_t op;
        logic     present_clr;
        logic     present_clr_bit;
    } bfac_cmd_t;

    typedef struct packed {
        logic seed_done;
        logic is_check;
        logic mul_last;
    } bfac_sts_t;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    // Ops that run a 64-bit multiply by a constant.
    function automatic logic op_uses_mul(input bfac_op_t op);
        unique case (op)
            OP_L0A, OP_L0B, OP_MIX0, OP_L1A, OP_L1B, OP_MIX1, OP_W2, OP_MIX2,
            OP_F1, OP_F2: return 1'b1;
            default:      return 1'b0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== src/bloom_filter_add_check_core.sv =====
// Top level of the bloom filter add/check core.
//  channel | ports                         | payload
//  input   | s_valid / s_ready             | s_data (bfac_in_t)
//  result  | m_valid / m_ready             | m_data (bfac_out_t)
//  config  | cfg_we, cfg_index, cfg_wdata  | size_log2, hash_count
// After reset a clearing pass writes zero to every store bit, one per cycle,
// all 2^MAX_SIZE_LOG2 of them, with no item accepted meanwhile.
// Each 64-bit multiply by a constant runs on one 32x32 multiplier. A hash is the seed
// load, ten multiplies and three steps without a multiply; then the store bit is read
// and tested, written on an add, and the seed steps on to the next hash. A check that
// meets a clear bit goes straight to its result; an add runs every configured hash.
// One item is in work at a time; while the result waits for m_ready the input stalls.
`default_nettype none
module bloom_filter_add_check_core #(
    parameter int MAX_SIZE_LOG2 = 20,
    parameter int MAX_HASHES    = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bfac_pkg::bfac_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bfac_pkg::bfac_out_t       m_data,
    input  wire logic                 cfg_we,
    input  wire logic [4:0]           cfg_index,
    input  wire logic [4:0]           cfg_wdata
);
    import bfac_pkg::*;

    localparam int SEED_W = $clog2(MAX_HASHES + 1) + 1;

    logic [4:0] size_log2_reg, hash_count_reg;
    logic [4:0] size_eff;
    logic [SEED_W-1:0] seed_limit;
    bfac_cmd_t cmd;
    bfac_sts_t sts;
    logic [MAX_SIZE_LOG2-1:0] cell_addr, clr_addr, ram_addr;
    logic clr_active, st_we, rd_bit, present;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg  <= 5'd20;
            hash_count_reg <= 5'd4;
        end else if (cfg_we) begin
            if (cfg_index == {4'd0, CFG_SIZE_LOG2}) begin
                size_log2_reg <= cfg_wdata;
            end else if (cfg_index == {4'd0, CFG_HASH_COUNT}) begin
                hash_count_reg <= cfg_wdata;
            end
        end
    end

    // Oversized settings saturate at the build limits.
    assign size_eff = (32'(size_log2_reg) > MAX_SIZE_LOG2) ? 5'(MAX_SIZE_LOG2)
                                                            : size_log2_reg;
    assign seed_limit = (32'(hash_count_reg) > MAX_HASHES) ? SEED_W'(MAX_HASHES)
                                                           : SEED_W'(hash_count_reg);

    bfac_ctrl #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .rd_bit(rd_bit), .cmd(cmd),
        .clr_active(clr_active), .clr_addr(clr_addr), .st_we(st_we)
    );

    bfac_datapath #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2), .SEED_W(SEED_W)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_data), .cmd(cmd),
        .seed_limit(seed_limit), .size_lg(size_eff), .sts(sts),
        .cell_addr(cell_addr), .present(present)
    );

    // The store is written with zero during the clear sweep and one on adds.
    assign ram_addr = clr_active ? clr_addr : cell_addr;

    bfac_ram #(.WIDTH(1), .DEPTH(2 ** MAX_SIZE_LOG2)) u_store (
        .aclk(aclk), .we(st_we), .addr(ram_addr),
        .wdata(!clr_active), .rdata(rd_bit)
    );

    assign m_data.was_check     = sts.is_check;
    assign m_data.maybe_present = sts.is_check & present;

`ifndef SYNTHESIS
    a_add_not_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.was_check) |-> !m_data.maybe_present)
        else $error("add reported present");
    a_stable_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data)) else $error("result changed");
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !st_we) else $error("store write while idle");
`endif
endmodule
`default_nettype wire

// ===== src/bfac_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module bfac_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== src/bfac_datapath.sv =====
// Hash datapath: key hold, seed counter, XXH64 steps on a shared multiplier, result flag.
`default_nettype none
module bfac_datapath #(
    parameter int MAX_SIZE_LOG2 = 20,
    parameter int SEED_W = 7
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire bfac_pkg::bfac_in_t      in_item,
    input  wire bfac_pkg::bfac_cmd_t     cmd,
    input  wire logic [SEED_W-1:0]       seed_limit,
    input  wire logic [4:0]              size_lg,
    output bfac_pkg::bfac_sts_t          sts,
    output logic [MAX_SIZE_LOG2-1:0]     cell_addr,
    output logic                         present
);
    import bfac_pkg::*;

    logic [63:0] w0_reg, w1_reg, w2_reg;
    logic        chk_reg;
    logic [SEED_W-1:0] seed_reg;
    logic [63:0] h_reg, h_next, a_reg, a_next;
    logic        present_reg;
    logic [MAX_SIZE_LOG2-1:0] mask;
    logic [1:0]  mph_reg;
    logic [63:0] prod_reg;
    logic [31:0] cross_reg;
    logic        mul_op, op_done;
    logic [63:0] mul_x, mul_c;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, mul_full;

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            w0_reg  <= in_item.key_bytes_0_7;
            w1_reg  <= in_item.key_bytes_8_15;
            w2_reg  <= {32'd0, in_item.key_bytes_16_19};
            chk_reg <= in_item.req_type;
        end
        h_reg <= h_next;
        a_reg <= a_next;
        unique case (mph_reg)
            2'd0:    prod_reg  <= mul_p;
            2'd1:    cross_reg <= mul_p[31:0];
            2'd2:    cross_reg <= cross_reg + mul_p[31:0];
            default: cross_reg <= cross_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= '0;
            present_reg <= 1'b0;
            mph_reg     <= '0;
        end else begin
            if (cmd.seed_clr) begin
                seed_reg <= '0;
            end else if (cmd.seed_inc) begin
                seed_reg <= seed_reg + 1'b1;
            end
            if (cmd.present_clr) begin
                present_reg <= 1'b1;
            end else if (cmd.present_clr_bit) begin
                present_reg <= 1'b0;
            end
            if (mul_op && !op_done) begin
                mph_reg <= mph_reg + 1'b1;
            end else begin
                mph_reg <= '0;
            end
        end
    end

    // Operand and constant of the multiply that the current op needs.
    always_comb begin
        mul_x = '0;
        mul_c = '0;
        unique case (cmd.op)
            OP_L0A: begin
                mul_x = w0_reg;
                mul_c = PR2;
            end
            OP_L1A: begin
                mul_x = w1_reg;
                mul_c = PR2;
            end
            OP_L0B, OP_L1B: begin
                mul_x = rotl(a_reg, 31);
                mul_c = PR1;
            end
            OP_MIX0, OP_MIX1: begin
                mul_x = rotl(h_reg, 27);
                mul_c = PR1;
            end
            OP_W2: begin
                mul_x = w2_reg;
                mul_c = PR1;
            end
            OP_MIX2: begin
                mul_x = rotl(h_reg, 23);
                mul_c = PR2;
            end
            OP_F1: begin
                mul_x = h_reg ^ (h_reg >> 33);
                mul_c = PR2;
            end
            OP_F2: begin
                mul_x = h_reg ^ (h_reg >> 29);
                mul_c = PR3;
            end
            default: begin
                mul_x = '0;
                mul_c = '0;
            end
        endcase
    end

    // The low 64 bits of a 64x64 product come from three 32x32 products on
    // one multiplier: low*low, then the two cross terms, summed in a
    // register and added to the registered low product.
    always_comb begin
        unique case (mph_reg)
            2'd0: begin
                mul_a = mul_x[31:0];
                mul_b = mul_c[31:0];
            end
            2'd1: begin
                mul_a = mul_x[31:0];
                mul_b = mul_c[63:32];
            end
            default: begin
                mul_a = mul_x[63:32];
                mul_b = mul_c[31:0];
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign mul_full = prod_reg + {cross_reg, 32'd0};
    assign mul_op   = op_uses_mul(cmd.op);
    assign op_done  = !mul_op || (mph_reg == 2'd3);

    always_comb begin
        h_next = h_reg;
        a_next = a_reg;
        unique case (cmd.op)
            OP_INIT: h_next = {{(64-SEED_W){1'b0}}, seed_reg} + PR5 + KEY_LEN;
            OP_L0A, OP_L0B, OP_L1A, OP_L1B: begin
                if (op_done) begin
                    a_next = mul_full;
                end
            end
            OP_L0C, OP_L1C: h_next = h_reg ^ a_reg;
            OP_MIX0, OP_MIX1: begin
                if (op_done) begin
                    h_next = mul_full + PR4;
                end
            end
            OP_W2: begin
                if (op_done) begin
                    h_next = h_reg ^ mul_full;
                end
            end
            OP_MIX2: begin
                if (op_done) begin
                    h_next = mul_full + PR3;
                end
            end
            OP_F1, OP_F2: begin
                if (op_done) begin
                    h_next = mul_full;
                end
            end
            OP_F3:   h_next = h_reg ^ (h_reg >> 32);
            default: begin
                h_next = h_reg;
                a_next = a_reg;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
            mask[i] = (5'(i) < size_lg);
        end
    end

    assign cell_addr     = h_reg[MAX_SIZE_LOG2-1:0] & mask;
    assign present       = present_reg;
    assign sts.seed_done = (seed_reg >= seed_limit);
    assign sts.is_check  = chk_reg;
    assign sts.mul_last  = (mph_reg == 2'd3);
endmodule
`default_nettype wire

// ===== src/bfac_ctrl.sv =====
// Controller state machine: store clear sweep, hash sequencing, store access, result.
`default_nettype none
module bfac_ctrl #(
    parameter int MAX_SIZE_LOG2 = 20
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire bfac_pkg::bfac_sts_t    sts,
    input  wire logic                   rd_bit,
    output bfac_pkg::bfac_cmd_t         cmd,
    output logic                        clr_active,
    output logic [MAX_SIZE_LOG2-1:0]    clr_addr,
    output logic                        st_we
);
    import bfac_pkg::*;

    bfac_state_t state_reg, state_next;
    bfac_op_t    op_reg, op_next;
    logic [MAX_SIZE_LOG2-1:0] clr_reg, clr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            op_reg    <= OP_INIT;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        cmd.op     = OP_HOLD;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        st_we      = 1'b0;
        clr_active = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_active = 1'b1;
                st_we      = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_key    = 1'b1;
                    cmd.seed_clr    = 1'b1;
                    cmd.present_clr = 1'b1;
                    state_next      = ST_START;
                end
            end
            ST_START: begin
                if (sts.seed_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.op     = OP_INIT;
                    op_next    = OP_L0A;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                cmd.op = op_reg;
                if (!op_uses_mul(op_reg) || sts.mul_last) begin
                    op_next = bfac_op_t'(op_reg + 1'b1);
                    if (op_reg == OP_F3) begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_RDWAIT;
            end
            ST_RDWAIT: begin
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (sts.is_check) begin
                    if (!rd_bit) begin
                        cmd.present_clr_bit = 1'b1;
                        state_next          = ST_OUT;
                    end else begin
                        state_next = ST_NEXT;
                    end
                end else begin
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                st_we      = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                cmd.seed_inc = 1'b1;
                state_next   = ST_START;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign clr_addr = clr_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("ready while result pending");
    a_clear_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active |-> !s_ready) else $error("accept during clear");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== sim/bloom_filter_add_check_core_test.sv =====
// Self-checking testbench for the bloom filter add/check core.
`default_nettype none
module bloom_filter_add_check_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bfac_pkg::*;

    // Filter geometry of the instance, kept at the default parameters.
    localparam int FILTER_LOG2 = 20;
    localparam int HASH_LIMIT  = 16;

    // Register indexes of the configuration port. The two spare indexes are
    // not backed by a register and must leave the filter setup untouched.
    localparam logic [4:0] REG_SIZE_LOG2  = 5'(CFG_SIZE_LOG2);
    localparam logic [4:0] REG_HASH_COUNT = 5'(CFG_HASH_COUNT);
    localparam logic [4:0] REG_SPARE_LO   = 5'd2;
    localparam logic [4:0] REG_SPARE_HI   = 5'd31;

    // Idling modes of the two channels.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // The clearing pass after reset walks all 2^20 cells before the first
    // item is taken, so the watchdog has to outlast it by a clear margin.
    localparam int STALL_LIMIT = 4_200_000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    bfac_in_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    bfac_out_t  m_data;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_index = '0;
    logic [4:0] cfg_wdata = '0;

    bloom_filter_add_check_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: our own copy of the cell store and of both registers.
    // ------------------------------------------------------------------
    bit         filter_cells [0:(1 << FILTER_LOG2) - 1];
    logic [4:0] cur_size_log2  = 5'd20;
    logic [4:0] cur_hash_count = 5'd4;

    bfac_out_t  pending_results [$];
    int         fail_count = 0;

    // Idling controls of the sender and the receiver.
    int sender_gap_pct   = 0;
    int receiver_hold_pct = 0;
    int receiver_block_cycles = 0;

    function automatic logic [63:0] rot64(input logic [63:0] v, input int amount);
        return (v << amount) | (v >> (64 - amount));
    endfunction

    function automatic logic [63:0] lane_mix(input logic [63:0] lane);
        logic [63:0] acc;
        acc = lane * PR2;
        acc = rot64(acc, 31);
        return acc * PR1;
    endfunction

    // XXH64 of the fixed 20-byte key: two full lanes, then one 32-bit word.
    function automatic logic [63:0] xxh64_key(input bfac_in_t it, input logic [63:0] seed);
        logic [63:0] h;
        h = seed + PR5 + KEY_LEN;
        h ^= lane_mix(it.key_bytes_0_7);
        h = rot64(h, 27) * PR1 + PR4;
        h ^= lane_mix(it.key_bytes_8_15);
        h = rot64(h, 27) * PR1 + PR4;
        h ^= {32'd0, it.key_bytes_16_19} * PR1;
        h = rot64(h, 23) * PR2 + PR3;
        h ^= h >> 33;
        h *= PR2;
        h ^= h >> 29;
        h *= PR3;
        h ^= h >> 32;
        return h;
    endfunction

    // Applies one item to the cell store and returns the result it gives.
    function automatic bfac_out_t filter_apply(input bfac_in_t it);
        bfac_out_t   res;
        int          eff_log2;
        int          eff_hashes;
        logic [63:0] cell_mask;
        logic [63:0] cell_idx;
        bit          all_set;
        eff_log2   = (cur_size_log2 > FILTER_LOG2) ? FILTER_LOG2 : int'(cur_size_log2);
        eff_hashes = (cur_hash_count > HASH_LIMIT) ? HASH_LIMIT : int'(cur_hash_count);
        cell_mask  = (64'd1 << eff_log2) - 64'd1;
        all_set    = 1'b1;
        for (int s = 0; s < eff_hashes; s++) begin
            cell_idx = xxh64_key(it, 64'(s)) & cell_mask;
            if (it.req_type == REQ_CHECK) begin
                // A check stops at the first clear cell.
                if (!filter_cells[cell_idx]) begin
                    all_set = 1'b0;
                    break;
                end
            end else begin
                filter_cells[cell_idx] = 1'b1;
            end
        end
        res.was_check     = it.req_type;
        res.maybe_present = (it.req_type == REQ_CHECK) ? all_set : 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side. The valid is never lowered at the edge where it must
    // stay up for the next item; a gap lowers it once, then waits.
    // ------------------------------------------------------------------
    task automatic offer_item(input bfac_in_t it, input bit has_typed,
                              input bfac_out_t typed_res);
        int        gap;
        bfac_out_t predicted;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_gap_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        // The item went in at this edge, so the store is updated in order.
        predicted = filter_apply(it);
        pending_results.push_back(has_typed ? typed_res : predicted);
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
    endtask

    // Register writes happen only once every result has come back, since
    // each item gives exactly one result and one item is in work at a time.
    task automatic write_reg(input logic [4:0] idx, input logic [4:0] value);
        wait (pending_results.size() == 0);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_SIZE_LOG2)
            cur_size_log2 = value;
        else if (idx == REG_HASH_COUNT)
            cur_hash_count = value;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        sender_gap_pct    = (mode == IDLE_SENDER)   ? 51 :
                            (mode == IDLE_BOTH)     ? 8  : 0;
        receiver_hold_pct = (mode == IDLE_RECEIVER) ? 51 :
                            (mode == IDLE_BOTH)     ? 8  : 0;
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and the field-by-field comparison.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bfac_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation: was_check=%0d maybe_present=%0d",
                       m_data.was_check, m_data.maybe_present);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.was_check !== want.was_check) begin
                    $error("was_check: expected %0d, got %0d",
                           want.was_check, m_data.was_check);
                    fail_count++;
                end
                if (m_data.maybe_present !== want.maybe_present) begin
                    $error("maybe_present: expected %0d, got %0d",
                           want.maybe_present, m_data.maybe_present);
                    fail_count++;
                end
            end
        end
        // A long hold-off is counted down here, in the receiver's own
        // process, while the sender keeps offering items.
        if (receiver_block_cycles > 0) begin
            receiver_block_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !($urandom_range(99) < receiver_hold_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("bloom_filter_add_check_core_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed rows at the reset setup (2^20 cells, four hashes).
    // ------------------------------------------------------------------
    typedef struct {
        logic        op;
        logic [63:0] k0;
        logic [63:0] k1;
        logic [31:0] k2;
        bit          typed;
        logic        present;
    } directed_row_t;

    directed_row_t directed_rows [] = '{
        // On the cleared store a check can never find its cells set.
        '{REQ_CHECK, 64'h0, 64'h0, 32'h0, 1'b1, 1'b0},
        '{REQ_ADD,   64'h0, 64'h0, 32'h0, 1'b1, 1'b0},
        // A key just added is always reported as maybe present.
        '{REQ_CHECK, 64'h0, 64'h0, 32'h0, 1'b1, 1'b1},
        '{REQ_ADD,   '1, '1, '1, 1'b1, 1'b0},
        '{REQ_CHECK, '1, '1, '1, 1'b1, 1'b1},
        '{REQ_CHECK, 64'h1, 64'h0, 32'h0, 1'b0, 1'b0},
        '{REQ_ADD,   '1, 64'h0, '1, 1'b1, 1'b0},
        '{REQ_CHECK, '1, 64'h0, '1, 1'b1, 1'b1},
        '{REQ_CHECK, 64'h0, '1, 32'h0, 1'b0, 1'b0},
        '{REQ_CHECK, 64'h5555555555555555, 64'h5555555555555555, 32'h55555555, 1'b0, 1'b0},
        '{REQ_ADD,   64'hAAAAAAAAAAAAAAAA, 64'hAAAAAAAAAAAAAAAA, 32'hAAAAAAAA, 1'b1, 1'b0},
        '{REQ_CHECK, 64'hAAAAAAAAAAAAAAAA, 64'hAAAAAAAAAAAAAAAA, 32'hAAAAAAAA, 1'b1, 1'b1},
        '{REQ_CHECK, 64'h8000000000000000, 64'h8000000000000000, 32'h80000000, 1'b0, 1'b0}
    };

    // Random phases: setup, idling and item count. The list takes in the
    // extremes of both registers, sizes above the limit and below three,
    // and a hash count of zero as well as above the limit.
    typedef struct {
        logic [4:0] size_log2;
        logic [4:0] hash_count;
        idle_mode_t mode;
        int         items;
    } phase_t;

    phase_t phases [] = '{
        '{5'd3,  5'd1,  IDLE_NONE,     150},
        '{5'd20, 5'd16, IDLE_SENDER,   60},
        '{5'd0,  5'd2,  IDLE_RECEIVER, 120},
        '{5'd31, 5'd3,  IDLE_BOTH,     180},
        '{5'd5,  5'd0,  IDLE_NONE,     100},
        '{5'd8,  5'd31, IDLE_RECEIVER, 40},
        '{5'd10, 5'd2,  IDLE_SENDER,   200},
        '{5'd4,  5'd4,  IDLE_BOTH,     200},
        '{5'd12, 5'd1,  IDLE_RECEIVER, 200},
        '{5'd6,  5'd3,  IDLE_NONE,     200}
    };

    bfac_in_t key_pool [$];

    function automatic bfac_in_t random_key();
        bfac_in_t k;
        k.key_bytes_0_7   = {$urandom, $urandom};
        k.key_bytes_8_15  = {$urandom, $urandom};
        k.key_bytes_16_19 = $urandom;
        k.req_type        = REQ_ADD;
        return k;
    endfunction

    // Most items reuse keys added earlier in the phase, so that checks hit
    // keys that are present as often as they miss; the rest are fresh keys.
    function automatic bfac_in_t next_random_item();
        bfac_in_t it;
        if (key_pool.size() > 0 && $urandom_range(99) < 60)
            it = key_pool[$urandom_range(key_pool.size() - 1)];
        else
            it = random_key();
        it.req_type = $urandom_range(1) ? REQ_CHECK : REQ_ADD;
        if (it.req_type == REQ_ADD) begin
            key_pool.push_back(it);
            if (key_pool.size() > 64)
                void'(key_pool.pop_front());
        end
        return it;
    endfunction

    initial begin
        bfac_in_t  it;
        bfac_out_t typed_res;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset setup, no idling.
        set_idling(IDLE_NONE);
        foreach (directed_rows[i]) begin
            it.req_type        = directed_rows[i].op;
            it.key_bytes_0_7   = directed_rows[i].k0;
            it.key_bytes_8_15  = directed_rows[i].k1;
            it.key_bytes_16_19 = directed_rows[i].k2;
            typed_res.was_check     = directed_rows[i].op;
            typed_res.maybe_present = directed_rows[i].present;
            offer_item(it, directed_rows[i].typed, typed_res);
        end
        drop_valid();

        // Writes to indexes with no register behind them change nothing.
        write_reg(REG_SPARE_LO, 5'd3);
        write_reg(REG_SPARE_HI, 5'd0);

        foreach (phases[p]) begin
            write_reg(REG_SIZE_LOG2, phases[p].size_log2);
            write_reg(REG_HASH_COUNT, phases[p].hash_count);
            set_idling(phases[p].mode);
            key_pool.delete();
            for (int n = 0; n < phases[p].items; n++)
                offer_item(next_random_item(), 1'b0, typed_res);
            drop_valid();
        end

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps offering, so the core fills and stops taking items.
        write_reg(REG_SIZE_LOG2, 5'd7);
        write_reg(REG_HASH_COUNT, 5'd2);
        set_idling(IDLE_NONE);
        receiver_block_cycles = 600;
        for (int n = 0; n < 100; n++)
            offer_item(next_random_item(), 1'b0, typed_res);
        drop_valid();

        wait (pending_results.size() == 0);
        repeat (400) @(posedge aclk);
        if (fail_count == 0) begin
            $display("bloom_filter_add_check_core_test passed");
        end else begin
            $display("bloom_filter_add_check_core_test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
src/bfac_pkg.sv
src/bfac_ram.sv
src/bfac_datapath.sv
src/bfac_ctrl.sv
src/bloom_filter_add_check_core.sv
sim/bloom_filter_add_check_core_test.sv
